// ===== rtl/dpcr_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and helpers for the disc pair collision core.
package dpcr_pkg;

    localparam int FRAC_BITS  = 4;
    localparam int GUARD_BITS = 8;
    localparam int POS_W      = 16;
    localparam int RAD_W      = 8;
    localparam int MASS_W     = 8;

    // On a collision |dx| and |dy| stay below (2*255) << FRAC_BITS.
    localparam int DX_W   = 14;
    localparam int DIFF_W = POS_W + 1;
    localparam int SQR_W  = 2 * DIFF_W;
    localparam int DOT_W  = 32;
    localparam int D2_W   = 26;
    localparam int RSUM_W = RAD_W + 1;
    localparam int MSUM_W = MASS_W + 1;
    localparam int RQ_W   = RSUM_W + FRAC_BITS;

    localparam int SQ_IN_W  = D2_W + 2 * GUARD_BITS;
    localparam int SQ_OUT_W = SQ_IN_W / 2;
    localparam int SQ_LAT   = SQ_OUT_W;

    localparam int TV_W  = DOT_W + DX_W;
    localparam int PR_W  = SQ_OUT_W + RAD_W;
    localparam int NUM_DIV = 8;

    localparam int DIV_NW = 53;
    localparam int DIV_DW = 35;
    localparam int DIV_QB = 20;

    localparam int SUM_W    = DIV_QB + 2;
    localparam int PIPE_LAT = 3 + SQ_LAT + 3 + DIV_QB + 1;

    typedef logic signed [POS_W-1:0] q_t;

    typedef struct packed {
        q_t               first_x;
        q_t               first_y;
        q_t               first_vx;
        q_t               first_vy;
        logic [RAD_W-1:0]  first_radius;
        logic [MASS_W-1:0] first_mass;
        q_t               second_x;
        q_t               second_y;
        q_t               second_vx;
        q_t               second_vy;
        logic [RAD_W-1:0]  second_radius;
        logic [MASS_W-1:0] second_mass;
    } pair_in_t;

    typedef struct packed {
        logic collided;
        q_t   new_first_x;
        q_t   new_first_y;
        q_t   new_first_vx;
        q_t   new_first_vy;
        q_t   new_second_x;
        q_t   new_second_y;
        q_t   new_second_vx;
        q_t   new_second_vy;
    } pair_out_t;

    // Per-item context carried alongside the arithmetic units.
    typedef struct packed {
        pair_in_t                 disc;
        logic signed [DX_W-1:0]   dx;
        logic signed [DX_W-1:0]   dy;
        logic signed [DOT_W-1:0]  dot;
        logic [D2_W-1:0]          d2;
        logic [MASS_W-1:0]        m1;
        logic [MASS_W-1:0]        m2;
        logic [MSUM_W-1:0]        msum;
        logic [RSUM_W-1:0]        rsum;
        logic                     hit;
    } ctx_t;

    function automatic q_t sat16(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        hi = SUM_W'(32767);
        lo = -SUM_W'(32768);
        if (v > hi) begin
            return q_t'(hi);
        end
        if (v < lo) begin
            return q_t'(lo);
        end
        return v[POS_W-1:0];
    endfunction

endpackage

// ===== rtl/dpcr_ifs.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for disc pairs and their results.
interface dpcr_pair_if;
    import dpcr_pkg::*;
    logic     valid;
    logic     ready;
    pair_in_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface dpcr_result_if;
    import dpcr_pkg::*;
    logic      valid;
    logic      ready;
    pair_out_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/dpcr_sqrt.sv =====
`timescale 1ns / 1ps
// Pipelined integer square root, one result bit per stage.
module dpcr_sqrt
    import dpcr_pkg::*;
(
    input  logic                clk,
    input  logic                en,
    input  logic [SQ_IN_W-1:0]  rad,
    output logic [SQ_OUT_W-1:0] root
);

    localparam int W = SQ_IN_W + 1;

    logic [W-1:0] v_reg   [SQ_LAT];
    logic [W-1:0] res_reg [SQ_LAT];

    for (genvar i = 0; i < SQ_LAT; i++) begin : g_stage
        localparam logic [W-1:0] BIT = {{(W-1){1'b0}}, 1'b1} << (SQ_IN_W - 2 - 2 * i);
        logic [W-1:0] v_in;
        logic [W-1:0] res_in;
        logic [W-1:0] trial;
        logic [W-1:0] v_next;
        logic [W-1:0] res_next;

        if (i == 0) begin : g_first
            assign v_in   = {1'b0, rad};
            assign res_in = '0;
        end
        else begin : g_rest
            assign v_in   = v_reg[i-1];
            assign res_in = res_reg[i-1];
        end

        always_comb
        begin
            trial = res_in + BIT;
            if (v_in >= trial)
            begin
                v_next   = v_in - trial;
                res_next = (res_in >> 1) + BIT;
            end
            else
            begin
                v_next   = v_in;
                res_next = res_in >> 1;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                v_reg[i]   <= v_next;
                res_reg[i] <= res_next;
            end
        end
    end

    assign root = res_reg[SQ_LAT-1][SQ_OUT_W-1:0];

endmodule

// ===== rtl/dpcr_div.sv =====
`timescale 1ns / 1ps
// Pipelined restoring divider, one quotient bit per stage, sign carried along.
module dpcr_div
    import dpcr_pkg::*;
(
    input  logic              clk,
    input  logic              en,
    input  logic [DIV_NW-1:0] num,
    input  logic [DIV_DW-1:0] den,
    input  logic              neg,
    output logic [DIV_QB-1:0] quo,
    output logic              quo_neg
);

    localparam int W = DIV_DW + DIV_QB;

    logic [DIV_NW-1:0] rem_reg [DIV_QB];
    logic [DIV_DW-1:0] den_reg [DIV_QB];
    logic [DIV_QB-1:0] q_reg   [DIV_QB];
    logic              neg_reg [DIV_QB];

    for (genvar i = 0; i < DIV_QB; i++) begin : g_stage
        localparam int B = DIV_QB - 1 - i;
        logic [DIV_NW-1:0] rem_in;
        logic [DIV_DW-1:0] den_in;
        logic [DIV_QB-1:0] q_in;
        logic              neg_in;
        logic [W-1:0]      rem_ext;
        logic [W-1:0]      dsh;
        logic [W-1:0]      diff;
        logic [DIV_NW-1:0] rem_next;
        logic [DIV_QB-1:0] q_next;

        if (i == 0) begin : g_first
            assign rem_in = num;
            assign den_in = den;
            assign q_in   = '0;
            assign neg_in = neg;
        end
        else begin : g_rest
            assign rem_in = rem_reg[i-1];
            assign den_in = den_reg[i-1];
            assign q_in   = q_reg[i-1];
            assign neg_in = neg_reg[i-1];
        end

        always_comb
        begin
            rem_ext = {{(W-DIV_NW){1'b0}}, rem_in};
            dsh     = {{(W-DIV_DW){1'b0}}, den_in} << B;
            diff    = rem_ext - dsh;
            q_next  = q_in;
            if (rem_ext >= dsh)
            begin
                rem_next  = diff[DIV_NW-1:0];
                q_next[B] = 1'b1;
            end
            else
            begin
                rem_next = rem_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i] <= rem_next;
                den_reg[i] <= den_in;
                q_reg[i]   <= q_next;
                neg_reg[i] <= neg_in;
            end
        end
    end

    assign quo     = q_reg[DIV_QB-1];
    assign quo_neg = neg_reg[DIV_QB-1];

endmodule

// ===== rtl/disc_pair_collision_resolve_core.sv =====
`timescale 1ns / 1ps
// Top level: elastic collision and separation of two discs, fully pipelined.
// Accepts one pair per cycle while no held result stalls the pipeline.
// The depth comes from the 21-stage square root and the 20-stage dividers.
// A held result freezes the whole pipeline, so nothing is lost or repeated.
// Reset clears only the stage valid bits; data registers are not reset.
module disc_pair_collision_resolve_core
    import dpcr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    dpcr_pair_if.sink   pairs,
    dpcr_result_if.source results
);

    logic                en;
    logic [PIPE_LAT-1:0] vld_reg;
    logic [PIPE_LAT-1:0] vld_next;

    assign en            = !vld_reg[PIPE_LAT-1] || results.ready;
    assign pairs.ready   = en;
    assign results.valid = vld_reg[PIPE_LAT-1];
    assign vld_next      = {vld_reg[PIPE_LAT-2:0], pairs.valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= vld_next;
        end
    end

    // Stage A: differences and mass handling.
    pair_in_t                  a_disc_reg;
    logic signed [DIFF_W-1:0]  a_dx_reg, a_dy_reg, a_dvx_reg, a_dvy_reg;
    logic [MASS_W-1:0]         a_m1_reg, a_m2_reg;
    logic [MSUM_W-1:0]         a_msum_reg;
    logic [RSUM_W-1:0]         a_rsum_reg;
    logic [MASS_W-1:0]         a_m1_next, a_m2_next;

    always_comb
    begin
        a_m1_next = pairs.data.first_mass;
        a_m2_next = pairs.data.second_mass;
        // Two massless discs collide as equal masses.
        if (a_m1_next == '0 && a_m2_next == '0)
        begin
            a_m1_next = MASS_W'(1);
            a_m2_next = MASS_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_disc_reg <= pairs.data;
            a_dx_reg   <= DIFF_W'(pairs.data.first_x) - DIFF_W'(pairs.data.second_x);
            a_dy_reg   <= DIFF_W'(pairs.data.first_y) - DIFF_W'(pairs.data.second_y);
            a_dvx_reg  <= DIFF_W'(pairs.data.first_vx) - DIFF_W'(pairs.data.second_vx);
            a_dvy_reg  <= DIFF_W'(pairs.data.first_vy) - DIFF_W'(pairs.data.second_vy);
            a_m1_reg   <= a_m1_next;
            a_m2_reg   <= a_m2_next;
            a_msum_reg <= MSUM_W'(a_m1_next) + MSUM_W'(a_m2_next);
            a_rsum_reg <= RSUM_W'(pairs.data.first_radius)
                          + RSUM_W'(pairs.data.second_radius);
        end
    end

    // Stage B: squares and approach products.
    pair_in_t                 b_disc_reg;
    logic signed [DIFF_W-1:0] b_dx_reg, b_dy_reg;
    logic signed [SQR_W-1:0]  b_dxx_reg, b_dyy_reg, b_pvx_reg, b_pvy_reg;
    logic [2*RQ_W-1:0]        b_rq2_reg;
    logic [MASS_W-1:0]        b_m1_reg, b_m2_reg;
    logic [MSUM_W-1:0]        b_msum_reg;
    logic [RSUM_W-1:0]        b_rsum_reg;
    logic [RQ_W-1:0]          b_rq;

    assign b_rq = {a_rsum_reg, {FRAC_BITS{1'b0}}};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_disc_reg <= a_disc_reg;
            b_dx_reg   <= a_dx_reg;
            b_dy_reg   <= a_dy_reg;
            b_dxx_reg  <= a_dx_reg * a_dx_reg;
            b_dyy_reg  <= a_dy_reg * a_dy_reg;
            b_pvx_reg  <= a_dvx_reg * a_dx_reg;
            b_pvy_reg  <= a_dvy_reg * a_dy_reg;
            b_rq2_reg  <= b_rq * b_rq;
            b_m1_reg   <= a_m1_reg;
            b_m2_reg   <= a_m2_reg;
            b_msum_reg <= a_msum_reg;
            b_rsum_reg <= a_rsum_reg;
        end
    end

    // Stage C: distance test and dot product.
    ctx_t                   c_ctx_reg;
    ctx_t                   c_ctx_next;
    logic [SQR_W:0]         c_d2;
    logic signed [SQR_W:0]  c_dot;

    always_comb
    begin
        c_d2  = {1'b0, b_dxx_reg} + {1'b0, b_dyy_reg};
        c_dot = {b_pvx_reg[SQR_W-1], b_pvx_reg} + {b_pvy_reg[SQR_W-1], b_pvy_reg};
        c_ctx_next.disc = b_disc_reg;
        c_ctx_next.dx   = b_dx_reg[DX_W-1:0];
        c_ctx_next.dy   = b_dy_reg[DX_W-1:0];
        c_ctx_next.dot  = c_dot[DOT_W-1:0];
        c_ctx_next.d2   = c_d2[D2_W-1:0];
        c_ctx_next.m1   = b_m1_reg;
        c_ctx_next.m2   = b_m2_reg;
        c_ctx_next.msum = b_msum_reg;
        c_ctx_next.rsum = b_rsum_reg;
        c_ctx_next.hit  = (c_d2 < (SQR_W+1)'(b_rq2_reg))
                          && (b_pvx_reg[SQR_W-1] || b_pvy_reg[SQR_W-1]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_ctx_reg <= c_ctx_next;
        end
    end

    // Square root of d2 with guard bits, context delayed alongside.
    logic [SQ_OUT_W-1:0] root;
    ctx_t                sq_ctx_reg [SQ_LAT];

    dpcr_sqrt u_sqrt (
        .clk  (clk),
        .en   (en),
        .rad  ({c_ctx_reg.d2, {(2*GUARD_BITS){1'b0}}}),
        .root (root)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_ctx_reg[0] <= c_ctx_reg;
            for (int i = 1; i < SQ_LAT; i++)
            begin
                sq_ctx_reg[i] <= sq_ctx_reg[i-1];
            end
        end
    end

    // Stage D: first products and denominators.
    ctx_t                   s_ctx;
    ctx_t                   d_ctx_reg;
    logic signed [TV_W-1:0] d_tvx_reg, d_tvy_reg;
    logic [PR_W-1:0]        d_pr1_reg, d_pr2_reg;
    logic [DIV_DW-1:0]      d_den_v_reg, d_den_p_reg;
    logic [SQ_OUT_W-1:0]    d_rbig, d_rdiff;

    assign s_ctx   = sq_ctx_reg[SQ_LAT-1];
    assign d_rbig  = {s_ctx.rsum, {(FRAC_BITS+GUARD_BITS){1'b0}}};
    assign d_rdiff = d_rbig - root;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_ctx_reg   <= s_ctx;
            d_tvx_reg   <= s_ctx.dot * s_ctx.dx;
            d_tvy_reg   <= s_ctx.dot * s_ctx.dy;
            d_pr1_reg   <= d_rdiff * s_ctx.disc.first_radius;
            d_pr2_reg   <= d_rdiff * s_ctx.disc.second_radius;
            d_den_v_reg <= s_ctx.msum * s_ctx.d2;
            d_den_p_reg <= DIV_DW'(root * s_ctx.rsum);
        end
    end

    // Stage E: signed numerators. Order: vx1, vy1, vx2, vy2, x1, y1, x2, y2.
    ctx_t                       e_ctx_reg;
    logic signed [DIV_NW:0]     e_num_reg [NUM_DIV];
    logic signed [DIV_NW:0]     e_num_next [NUM_DIV];
    logic [DIV_DW-1:0]          e_den_v_reg, e_den_p_reg;
    logic signed [TV_W+MASS_W:0] e_pv [4];
    logic signed [DX_W+PR_W:0]  e_pp [4];

    always_comb
    begin
        e_pv[0] = d_tvx_reg * $signed({1'b0, d_ctx_reg.m2});
        e_pv[1] = d_tvy_reg * $signed({1'b0, d_ctx_reg.m2});
        e_pv[2] = d_tvx_reg * $signed({1'b0, d_ctx_reg.m1});
        e_pv[3] = d_tvy_reg * $signed({1'b0, d_ctx_reg.m1});
        e_pp[0] = d_ctx_reg.dx * $signed({1'b0, d_pr1_reg});
        e_pp[1] = d_ctx_reg.dy * $signed({1'b0, d_pr1_reg});
        e_pp[2] = d_ctx_reg.dx * $signed({1'b0, d_pr2_reg});
        e_pp[3] = d_ctx_reg.dy * $signed({1'b0, d_pr2_reg});
        for (int k = 0; k < 4; k++)
        begin
            // The factor of two in the impulse is a left shift.
            e_num_next[k]     = {e_pv[k][DIV_NW-1:0], 1'b0};
            e_num_next[k + 4] = {{(DIV_NW-DX_W-PR_W){e_pp[k][DX_W+PR_W]}}, e_pp[k]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e_ctx_reg   <= d_ctx_reg;
            e_num_reg   <= e_num_next;
            e_den_v_reg <= d_den_v_reg;
            e_den_p_reg <= d_den_p_reg;
        end
    end

    // Stage F: magnitude plus half the divisor, for round half away from zero.
    ctx_t              f_ctx_reg;
    logic [DIV_NW-1:0] f_num_reg [NUM_DIV];
    logic [DIV_NW-1:0] f_num_next [NUM_DIV];
    logic [DIV_DW-1:0] f_den_reg [NUM_DIV];
    logic [DIV_DW-1:0] f_den_next [NUM_DIV];
    logic              f_neg_reg [NUM_DIV];
    logic              f_neg_next [NUM_DIV];

    always_comb
    begin
        logic signed [DIV_NW:0] negv;
        logic [DIV_NW-1:0]      mag;
        for (int k = 0; k < NUM_DIV; k++)
        begin
            f_den_next[k] = (k < 4) ? e_den_v_reg : e_den_p_reg;
            f_neg_next[k] = e_num_reg[k][DIV_NW];
            negv          = -e_num_reg[k];
            mag           = f_neg_next[k] ? negv[DIV_NW-1:0] : e_num_reg[k][DIV_NW-1:0];
            f_num_next[k] = mag + {{(DIV_NW-DIV_DW+1){1'b0}}, f_den_next[k][DIV_DW-1:1]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f_ctx_reg <= e_ctx_reg;
            f_num_reg <= f_num_next;
            f_den_reg <= f_den_next;
            f_neg_reg <= f_neg_next;
        end
    end

    // Dividers, context delayed alongside.
    logic [DIV_QB-1:0] quo [NUM_DIV];
    logic              quo_neg [NUM_DIV];
    ctx_t              dv_ctx_reg [DIV_QB];

    for (genvar k = 0; k < NUM_DIV; k++) begin : g_div
        dpcr_div u_div (
            .clk     (clk),
            .en      (en),
            .num     (f_num_reg[k]),
            .den     (f_den_reg[k]),
            .neg     (f_neg_reg[k]),
            .quo     (quo[k]),
            .quo_neg (quo_neg[k])
        );
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dv_ctx_reg[0] <= f_ctx_reg;
            for (int i = 1; i < DIV_QB; i++)
            begin
                dv_ctx_reg[i] <= dv_ctx_reg[i-1];
            end
        end
    end

    // Stage G: on a hit apply the deltas and saturate, then register the result.
    ctx_t                    g_ctx;
    logic signed [SUM_W-1:0] g_dlt [NUM_DIV];
    pair_out_t               out_reg;
    pair_out_t               out_next;

    assign g_ctx = dv_ctx_reg[DIV_QB-1];

    always_comb
    begin
        for (int k = 0; k < NUM_DIV; k++)
        begin
            g_dlt[k] = {{(SUM_W-DIV_QB){1'b0}}, quo[k]};
            if (quo_neg[k])
            begin
                g_dlt[k] = -g_dlt[k];
            end
        end
        out_next.collided = g_ctx.hit;
        if (g_ctx.hit)
        begin
            out_next.new_first_vx  = sat16(SUM_W'(g_ctx.disc.first_vx) - g_dlt[0]);
            out_next.new_first_vy  = sat16(SUM_W'(g_ctx.disc.first_vy) - g_dlt[1]);
            out_next.new_second_vx = sat16(SUM_W'(g_ctx.disc.second_vx) + g_dlt[2]);
            out_next.new_second_vy = sat16(SUM_W'(g_ctx.disc.second_vy) + g_dlt[3]);
            out_next.new_first_x   = sat16(SUM_W'(g_ctx.disc.first_x) + g_dlt[4]);
            out_next.new_first_y   = sat16(SUM_W'(g_ctx.disc.first_y) + g_dlt[5]);
            out_next.new_second_x  = sat16(SUM_W'(g_ctx.disc.second_x) - g_dlt[6]);
            out_next.new_second_y  = sat16(SUM_W'(g_ctx.disc.second_y) - g_dlt[7]);
        end
        else
        begin
            out_next.new_first_vx  = g_ctx.disc.first_vx;
            out_next.new_first_vy  = g_ctx.disc.first_vy;
            out_next.new_second_vx = g_ctx.disc.second_vx;
            out_next.new_second_vy = g_ctx.disc.second_vy;
            out_next.new_first_x   = g_ctx.disc.first_x;
            out_next.new_first_y   = g_ctx.disc.first_y;
            out_next.new_second_x  = g_ctx.disc.second_x;
            out_next.new_second_y  = g_ctx.disc.second_y;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_reg <= out_next;
        end
    end

    assign results.data = out_reg;

endmodule

// ===== rtl/dpcr_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the disc pair collision core, bound to the top level.
module dpcr_checker
    import dpcr_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_ready,
    input logic      out_valid,
    input logic      out_ready,
    input pair_out_t out_data
);

    // A waiting result keeps its valid.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // A waiting result keeps its value.
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_data))
        else $error("result changed while stalled");

    // The input side only stalls when a finished result is held.
    a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid |-> (in_ready == (!out_valid || out_ready)))
        else $error("input ready does not follow the output stall");

endmodule

bind disc_pair_collision_resolve_core dpcr_checker u_dpcr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (pairs.valid),
    .in_ready  (pairs.ready),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .out_data  (results.data)
);
